// ----- hw/rtl/gak_pkg.sv -----
// Shared types, constants and the exp2 fraction table for the Gaussian affinity kernel.
// Used by gak_seq, gak_datapath and the top level; depends on nothing else.
`default_nettype none

package gak_pkg;

  // default feature width (signed Q8.8)
  localparam int FEATURE_WIDTH_DEF = 16;

  // configuration register
  localparam int                 CFG_W           = 32;
  localparam logic [CFG_W-1:0]   INV_WIDTH_RESET = 32'd65536;

  // running sum of squared differences, unsigned Q25.16
  localparam int                 SUM_W   = 41;
  localparam logic [SUM_W-1:0]   SUM_MAX = {SUM_W{1'b1}};

  // magnitudes at or above 2^SQ_IN_W saturate the sum
  localparam int SQ_IN_W = 21;

  // shared multiplier operand width
  localparam int MUL_W = 32;

  // scaled distance: values at or above 2^X_LIM_W (16.0 in Q.16) give zero
  localparam int X_W     = 43;
  localparam int X_LIM_W = 20;

  // log2(e) in Q1.16
  localparam int               LOG2E_W   = 17;
  localparam logic [LOG2E_W-1:0] LOG2E_Q16 = 17'd94548;

  // y = x * log2(e), Q.16: 5 integer bits, 3 table bits, 13 interpolation bits
  localparam int Y_W    = 21;
  localparam int N_W    = 5;
  localparam int IDX_W  = 3;
  localparam int FRAC_W = 13;

  // table values and result
  localparam int TAB_W = 17;
  localparam int AFF_W = 16;

  // shared unit operations
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_SQ     = 3'd1;
  localparam logic [2:0] OP_LO     = 3'd2;
  localparam logic [2:0] OP_HI     = 3'd3;
  localparam logic [2:0] OP_LOG    = 3'd4;
  localparam logic [2:0] OP_INTERP = 3'd5;

  typedef logic [2:0] op_t;

  // sequencer to datapath control
  typedef struct packed {
    logic capture;  // register |a - b| of the accepted request
    logic acc;      // accumulate the square into the sum
    logic mul_en;   // load the product register
    logic x_en;     // register scaled distance, clear the sum
    logic y_en;     // register shift count and table base
    logic fin;      // load the result register
    op_t  op;       // operand selection for the shared multiplier
  } ctrl_t;

  // 2^(-i/8) in Q16, i = 0..8
  function automatic logic [TAB_W-1:0] exp2_tab(input logic [3:0] idx);
    logic [TAB_W-1:0] val;
    case (idx)
      4'd0:    val = 17'd65536;
      4'd1:    val = 17'd60097;
      4'd2:    val = 17'd55109;
      4'd3:    val = 17'd50535;
      4'd4:    val = 17'd46341;
      4'd5:    val = 17'd42495;
      4'd6:    val = 17'd38968;
      4'd7:    val = 17'd35734;
      4'd8:    val = 17'd32768;
      default: val = 17'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gaussian_affinity_kernel.sv -----
// Top level of the Gaussian affinity kernel.
// Depends on gak_pkg, gak_seq and gak_datapath.
`default_nettype none

// Streams element pairs of two signed feature vectors and returns
// exp(-inv_width * sum((a-b)^2)) as unsigned Q0.16 once per vector, on the pair marked
// last; the sum is then cleared and saturates at 2^41-1 on overflow. A pair without last
// is accepted (IDLE), then squared and accumulated (SQ); a last pair goes on through LO,
// HI, LOG, INTERP and FIN, where it waits for the output register to be taken. One 32x32
// multiplier is shared by every step: the square, the two halves of the width scaling,
// the log2(e) scaling and the table interpolation, so the exp tail costs four extra
// multiplier passes and a final shift. in_ready drops while a request is being worked on.
// A finished result waits in its own register, so the next vector may start streaming
// before it is taken. cfg_ready is always high; write inv_width only while no request is
// in flight. No clearing pass after reset.
module gaussian_affinity_kernel #(
  parameter int FEATURE_WIDTH = gak_pkg::FEATURE_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [gak_pkg::CFG_W-1:0]       inv_width,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [FEATURE_WIDTH-1:0] feature_a,
  input  wire logic signed [FEATURE_WIDTH-1:0] feature_b,
  input  wire logic                            last,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [gak_pkg::AFF_W-1:0]            affinity
);

  gak_pkg::ctrl_t ctrl;
  logic           cfg_we;

  // configuration is always taken
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  gak_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  gak_datapath #(
    .FEATURE_WIDTH (FEATURE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (inv_width),
    .feature_a (feature_a),
    .feature_b (feature_b),
    .ctrl      (ctrl),
    .affinity  (affinity)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/gak_seq.sv -----
// Sequencer for the Gaussian affinity kernel: input and output handshakes and the
// step order of the shared multiplier. Depends on gak_pkg.
`default_nettype none

module gak_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          last,
  output logic               out_valid,
  input  wire logic          out_ready,
  output gak_pkg::ctrl_t     ctrl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQ     = 3'd1;
  localparam logic [2:0] S_LO     = 3'd2;
  localparam logic [2:0] S_HI     = 3'd3;
  localparam logic [2:0] S_LOG    = 3'd4;
  localparam logic [2:0] S_INTERP = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       last_q;
  logic       in_take;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // step decode
  always_comb begin
    state_next   = state;
    ctrl         = '0;
    ctrl.op      = gak_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        ctrl.capture = in_take;
        if (in_take) state_next = S_SQ;
      end
      S_SQ: begin
        ctrl.op  = gak_pkg::OP_SQ;
        ctrl.acc = 1'b1;
        state_next = last_q ? S_LO : S_IDLE;
      end
      S_LO: begin
        ctrl.op     = gak_pkg::OP_LO;
        ctrl.mul_en = 1'b1;
        state_next  = S_HI;
      end
      S_HI: begin
        ctrl.op    = gak_pkg::OP_HI;
        ctrl.x_en  = 1'b1;
        state_next = S_LOG;
      end
      S_LOG: begin
        ctrl.op     = gak_pkg::OP_LOG;
        ctrl.mul_en = 1'b1;
        state_next  = S_INTERP;
      end
      S_INTERP: begin
        ctrl.op     = gak_pkg::OP_INTERP;
        ctrl.mul_en = 1'b1;
        ctrl.y_en   = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        // wait for the output register to free up
        ctrl.fin = out_free;
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_take) last_q <= last;
      if (ctrl.fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gak_datapath.sv -----
// Datapath of the Gaussian affinity kernel: one shared 32x32 multiplier, the distance
// accumulator, the exp2 shift-and-table tail and the result register. Depends on gak_pkg.
`default_nettype none

module gak_datapath #(
  parameter int FEATURE_WIDTH = gak_pkg::FEATURE_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [gak_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic signed [FEATURE_WIDTH-1:0]    feature_a,
  input  wire logic signed [FEATURE_WIDTH-1:0]    feature_b,
  input  wire gak_pkg::ctrl_t                     ctrl,
  output logic [gak_pkg::AFF_W-1:0]               affinity
);

  localparam int SQ_IN_W = gak_pkg::SQ_IN_W;
  localparam int SUM_W   = gak_pkg::SUM_W;
  localparam int MUL_W   = gak_pkg::MUL_W;
  localparam int X_W     = gak_pkg::X_W;
  localparam int X_LIM_W = gak_pkg::X_LIM_W;
  localparam int Y_W     = gak_pkg::Y_W;
  localparam int N_W     = gak_pkg::N_W;
  localparam int IDX_W   = gak_pkg::IDX_W;
  localparam int FRAC_W  = gak_pkg::FRAC_W;
  localparam int TAB_W   = gak_pkg::TAB_W;
  localparam int AFF_W   = gak_pkg::AFF_W;
  // magnitude extended far enough to test against 2^SQ_IN_W
  localparam int EXT_W   = (FEATURE_WIDTH > SQ_IN_W) ? FEATURE_WIDTH : SQ_IN_W + 1;
  // LOG product width and interpolation product width
  localparam int LOGP_W  = X_LIM_W + gak_pkg::LOG2E_W;
  localparam int INTP_W  = FRAC_W + FRAC_W;
  localparam int RND_W   = 48;

  logic [gak_pkg::CFG_W-1:0] inv_w;
  logic [SUM_W-1:0]          dist_sum;
  logic [SQ_IN_W-1:0]        mag;
  logic                      mag_big;
  logic [2*MUL_W-1:0]        prod;
  logic [X_LIM_W-1:0]        x_lo;
  logic                      x_big;
  logic [N_W-1:0]            n_sh;
  logic [TAB_W-1:0]          t_base;

  logic [FEATURE_WIDTH:0]    diff;
  logic [FEATURE_WIDTH:0]    diff_abs;
  logic [EXT_W-1:0]          mag_ext;
  logic [MUL_W-1:0]          mul_a;
  logic [MUL_W-1:0]          mul_b;
  logic [2*MUL_W-1:0]        mul_p;
  logic [2*SQ_IN_W-1:0]      sq;
  logic [SUM_W+1:0]          acc_sum;
  logic                      acc_sat;
  logic [X_W-1:0]            x_sum;
  logic [Y_W-1:0]            y;
  logic [IDX_W-1:0]          idx;
  logic [FRAC_W-1:0]         frac_r;
  logic [TAB_W-1:0]          tab_hi;
  logic [TAB_W-1:0]          tab_lo;
  logic [TAB_W-1:0]          tab_step;
  logic [INTP_W:0]           corr_sum;
  logic [TAB_W-1:0]          v;
  logic [RND_W-1:0]          rnd;
  logic [RND_W-1:0]          v_rnd;
  logic [RND_W-1:0]          v_sh;
  logic [AFF_W-1:0]          res;

  // |a - b| with one guard bit
  assign diff     = {feature_a[FEATURE_WIDTH-1], feature_a}
                  - {feature_b[FEATURE_WIDTH-1], feature_b};
  assign diff_abs = diff[FEATURE_WIDTH] ? ((~diff) + 1'b1) : diff;
  assign mag_ext  = EXT_W'(diff_abs[FEATURE_WIDTH-1:0]);

  // exp2 tail fields from the LOG product
  assign y        = prod[LOGP_W-1:16];
  assign idx      = y[FRAC_W+IDX_W-1:FRAC_W];
  assign frac_r   = y[FRAC_W-1:0];
  assign tab_hi   = gak_pkg::exp2_tab({1'b0, idx});
  assign tab_lo   = gak_pkg::exp2_tab(4'({1'b0, idx}) + 4'd1);
  assign tab_step = tab_hi - tab_lo;

  // shared multiplier operand select
  always_comb begin
    case (ctrl.op)
      gak_pkg::OP_SQ: begin
        mul_a = MUL_W'(mag);
        mul_b = MUL_W'(mag);
      end
      gak_pkg::OP_LO: begin
        mul_a = dist_sum[MUL_W-1:0];
        mul_b = inv_w;
      end
      gak_pkg::OP_HI: begin
        mul_a = MUL_W'(dist_sum[SUM_W-1:MUL_W]);
        mul_b = inv_w;
      end
      gak_pkg::OP_LOG: begin
        mul_a = MUL_W'(x_lo);
        mul_b = MUL_W'(gak_pkg::LOG2E_Q16);
      end
      gak_pkg::OP_INTERP: begin
        mul_a = MUL_W'(tab_step);
        mul_b = MUL_W'(frac_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // saturating accumulate
  assign sq      = mul_p[2*SQ_IN_W-1:0];
  assign acc_sum = (SUM_W+2)'(dist_sum) + (SUM_W+2)'(sq);
  assign acc_sat = mag_big || (acc_sum >= (SUM_W+2)'(gak_pkg::SUM_MAX));

  // x = floor(sum * w / 2^32): high partial product plus carried low half
  assign x_sum = X_W'(mul_p[SUM_W-1:0]) + X_W'(prod[2*MUL_W-1:MUL_W]);

  // interpolate, then rounding shift by the integer part
  assign corr_sum = (INTP_W+1)'(prod[INTP_W-1:0]) + (INTP_W+1)'(4096);
  assign v        = t_base - TAB_W'(corr_sum >> FRAC_W);
  assign rnd      = (n_sh == '0) ? '0 : (RND_W'(1) << (n_sh - N_W'(1)));
  assign v_rnd    = RND_W'(v) + rnd;
  assign v_sh     = v_rnd >> n_sh;

  always_comb begin
    if (x_big) begin
      res = '0;
    end else if (v_sh > RND_W'({AFF_W{1'b1}})) begin
      res = {AFF_W{1'b1}};
    end else begin
      res = v_sh[AFF_W-1:0];
    end
  end

  // configuration and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_w    <= gak_pkg::INV_WIDTH_RESET;
      dist_sum <= '0;
    end else begin
      if (cfg_we) inv_w <= cfg_data;
      if (ctrl.acc) begin
        dist_sum <= acc_sat ? gak_pkg::SUM_MAX : acc_sum[SUM_W-1:0];
      end else if (ctrl.x_en) begin
        dist_sum <= '0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      mag     <= mag_ext[SQ_IN_W-1:0];
      mag_big <= |(mag_ext >> SQ_IN_W);
    end
    if (ctrl.mul_en) prod <= mul_p;
    if (ctrl.x_en) begin
      x_lo  <= x_sum[X_LIM_W-1:0];
      x_big <= |x_sum[X_W-1:X_LIM_W];
    end
    if (ctrl.y_en) begin
      n_sh   <= y[Y_W-1:FRAC_W+IDX_W];
      t_base <= tab_hi;
    end
    if (ctrl.fin) affinity <= res;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gak_checker.sv -----
// Port-level checks for the Gaussian affinity kernel and the bind that attaches them.
// Depends on gaussian_affinity_kernel and gak_pkg.
`default_nettype none

module gak_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      last,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [gak_pkg::AFF_W-1:0] affinity
);

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // in_ready is low in the cycle after an accepted request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after a request");

  // a pair without last never produces a result in the next cycle
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !last && !out_valid) |=> !out_valid)
    else $error("result after a pair without last");

  // a new result only follows a busy cycle
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(affinity)))
    else $error("stalled result changed");

endmodule

bind gaussian_affinity_kernel gak_checker u_gak_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .last      (last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .affinity  (affinity)
);

`default_nettype wire
